FILE: rtl/triangle_half_plane_clipper_macros.svh
`ifndef TRIANGLE_HALF_PLANE_CLIPPER_MACROS_SVH
`define TRIANGLE_HALF_PLANE_CLIPPER_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define THPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, disabled while reset is asserted.
`define THPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/thpc_pkg.sv
// Shared types, constants and helper functions of the triangle half-plane clipper.
package thpc_pkg;

    localparam int COORD_BITS     = 24;
    localparam int QUOT_FRAC_BITS = 16;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int REM_BITS       = COORD_BITS + 2;
    localparam int PROD_BITS      = DIFF_BITS + QUOT_FRAC_BITS;
    localparam int TOL_BITS       = 21;
    localparam int WIDE_BITS      = DIFF_BITS + TOL_BITS;
    localparam int SB_LEN         = QUOT_FRAC_BITS + 2;

    localparam logic signed [TOL_BITS-1:0] TOL_SCALE = TOL_BITS'(1000000);

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_DROP  = 2'd0;
    localparam kind_t KIND_KEEP  = 2'd1;
    localparam kind_t KIND_SPLIT = 2'd2;
    localparam kind_t KIND_CUT   = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic [DIFF_BITS-1:0]         dmag_t;
    typedef logic [QUOT_FRAC_BITS-1:0]    quot_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vtx_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
    } dvec_t;

    typedef struct packed {
        logic   axis;
        logic   remove_greater;
        coord_t clip_value;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by_coord;
        coord_t cx;
        coord_t cy;
    } tri_req_t;

    typedef struct packed {
        coord_t out_x0;
        coord_t out_y0;
        coord_t out_x1;
        coord_t out_y1;
        coord_t out_x2;
        coord_t out_y2;
        logic   last_of_run;
    } clip_req_t;

    function automatic logic before_fn(input logic gt,
                                       input logic signed [WIDE_BITS-1:0] x,
                                       input logic signed [WIDE_BITS-1:0] y);
        before_fn = gt ? (x > y) : (x < y);
    endfunction

    function automatic logic before_c_fn(input logic gt, input coord_t x, input coord_t y);
        before_c_fn = gt ? (x > y) : (x < y);
    endfunction

    function automatic dmag_t mag_fn(input diff_t d);
        mag_fn = d[DIFF_BITS-1] ? dmag_t'(-d) : dmag_t'(d);
    endfunction

    function automatic coord_t pick_fn(input logic axis, input vtx_t v);
        pick_fn = axis ? v.y : v.x;
    endfunction

    function automatic dvec_t dvec_fn(input vtx_t q, input vtx_t p);
        dvec_t d;
        d.x = DIFF_BITS'(q.x) - DIFF_BITS'(p.x);
        d.y = DIFF_BITS'(q.y) - DIFF_BITS'(p.y);
        dvec_fn = d;
    endfunction

    function automatic clip_req_t tri_fn(input vtx_t v0, input vtx_t v1, input vtx_t v2,
                                         input logic last);
        clip_req_t r;
        r.out_x0      = v0.x;
        r.out_y0      = v0.y;
        r.out_x1      = v1.x;
        r.out_y1      = v1.y;
        r.out_x2      = v2.x;
        r.out_y2      = v2.y;
        r.last_of_run = last;
        tri_fn = r;
    endfunction

endpackage

FILE: rtl/thpc_div.sv
// Pipelined restoring divider that yields the fraction num / den, one quotient bit per stage.
module thpc_div (
    input  logic            clk,
    input  logic            adv,
    input  thpc_pkg::dmag_t num,
    input  thpc_pkg::dmag_t den,
    output thpc_pkg::quot_t quot
);
    import thpc_pkg::*;

    logic [REM_BITS-1:0] rem_reg  [QUOT_FRAC_BITS];
    logic [REM_BITS-1:0] rem_next [QUOT_FRAC_BITS];
    dmag_t               den_reg  [QUOT_FRAC_BITS];
    dmag_t               den_next [QUOT_FRAC_BITS];
    quot_t               q_reg    [QUOT_FRAC_BITS];
    quot_t               q_next   [QUOT_FRAC_BITS];

    for (genvar k = 0; k < QUOT_FRAC_BITS; k++) begin : g_step
        logic [REM_BITS-1:0] rem_prev;
        logic [REM_BITS-1:0] rem_sh;
        quot_t               q_prev;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_prev    = REM_BITS'(num);
            assign den_next[k] = den;
            assign q_prev      = '0;
        end else begin : g_rest
            assign rem_prev    = rem_reg[k-1];
            assign den_next[k] = den_reg[k-1];
            assign q_prev      = q_reg[k-1];
        end

        assign rem_sh      = {rem_prev[REM_BITS-2:0], 1'b0};
        assign ge          = rem_sh >= REM_BITS'(den_next[k]);
        assign rem_next[k] = ge ? (rem_sh - REM_BITS'(den_next[k])) : rem_sh;
        assign q_next[k]   = {q_prev[QUOT_FRAC_BITS-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quot = q_reg[QUOT_FRAC_BITS-1];

endmodule

FILE: rtl/thpc_lerp.sv
// Two-stage interpolation of a cut point p + t * d with truncation toward p.
module thpc_lerp (
    input  logic            clk,
    input  logic            adv,
    input  thpc_pkg::quot_t t,
    input  thpc_pkg::vtx_t  p,
    input  thpc_pkg::dvec_t d,
    output thpc_pkg::vtx_t  r
);
    import thpc_pkg::*;

    logic [PROD_BITS-1:0] prod_x_reg, prod_y_reg, prod_x_next, prod_y_next;
    logic                 neg_x_reg, neg_y_reg;
    vtx_t                 p_reg;
    dmag_t                sh_x, sh_y;
    diff_t                sum_x, sum_y;
    vtx_t                 r_reg, r_next;

    assign prod_x_next = PROD_BITS'(t) * PROD_BITS'(mag_fn(d.x));
    assign prod_y_next = PROD_BITS'(t) * PROD_BITS'(mag_fn(d.y));

    assign sh_x = prod_x_reg[QUOT_FRAC_BITS +: DIFF_BITS];
    assign sh_y = prod_y_reg[QUOT_FRAC_BITS +: DIFF_BITS];

    always_comb
    begin
        sum_x = neg_x_reg ? (DIFF_BITS'(p_reg.x) - sh_x) : (DIFF_BITS'(p_reg.x) + sh_x);
        sum_y = neg_y_reg ? (DIFF_BITS'(p_reg.y) - sh_y) : (DIFF_BITS'(p_reg.y) + sh_y);
        r_next.x = sum_x[COORD_BITS-1:0];
        r_next.y = sum_y[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            neg_x_reg  <= d.x[DIFF_BITS-1];
            neg_y_reg  <= d.y[DIFF_BITS-1];
            p_reg      <= p;
            r_reg      <= r_next;
        end
    end

    assign r = r_reg;

endmodule

FILE: rtl/triangle_half_plane_clipper.sv
// Top level of the triangle half-plane clipper: sort, classify, divide, interpolate, emit.
//
//   channel  | handshake             | payload    | items per request
//   tri      | tri_valid, tri_stall  | tri_req    | one triangle in
//   clip     | clip_valid, clip_stall| clip_req   | zero, one or two triangles out
//
// A request passes the stage 1 and 2 registers, the divider, the interpolation registers
// and the output register; the divider depth of one bit per stage sets its length.
// A request is taken every cycle unless the pipeline stalls; a split request is shown as
// two triangles and stalls the pipeline while the first is shown. A dropped request
// leaves an empty output slot. A stall on the output freezes the whole pipeline, so
// nothing is lost or repeated. Reset clears only the valid bits and the split phase.
module triangle_half_plane_clipper (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tri_valid,
    output logic                tri_stall,
    input  thpc_pkg::tri_req_t  tri_req,
    output logic                clip_valid,
    input  logic                clip_stall,
    output thpc_pkg::clip_req_t clip_req
);
    import thpc_pkg::*;

    typedef struct packed {
        logic   gt;
        logic   axis;
        coord_t clip;
        logic   mir;
        vtx_t   va;
        vtx_t   vb;
        vtx_t   vc;
        vtx_t   srt_a;
        vtx_t   srt_b;
        vtx_t   srt_c;
    } s1_t;

    typedef struct packed {
        logic   gt;
        logic   mir;
        kind_t  kind;
        vtx_t   va;
        vtx_t   vb;
        vtx_t   vc;
        vtx_t   srt_a;
        vtx_t   srt_b;
        vtx_t   srt_c;
        diff_t  dpar;
        diff_t  ac;
        dvec_t  d1;
        dvec_t  d2;
        dmag_t  num1;
        dmag_t  den1;
        dmag_t  num2;
        dmag_t  den2;
    } s2_t;

    typedef struct packed {
        kind_t  kind;
        logic   mir;
        vtx_t   va;
        vtx_t   vb;
        vtx_t   vc;
        vtx_t   srt_a;
        vtx_t   srt_b;
        vtx_t   srt_c;
        dvec_t  d1;
        dvec_t  d2;
    } sb_t;

    typedef struct packed {
        sb_t  sb;
        vtx_t c1;
        vtx_t c2;
    } oitem_t;

    logic   adv;
    logic   last_now;

    logic   v1_reg;
    s1_t    s1_reg, s1_next;
    logic   v2_reg;
    s2_t    s2_reg, s2_next;
    logic   sbv_reg [SB_LEN];
    sb_t    sb_reg  [SB_LEN];
    sb_t    sb_next;

    logic   ov_reg, ov_next;
    logic   phase_reg;
    oitem_t oi_reg, oi_next;

    quot_t  t1, t2;
    vtx_t   p2;
    vtx_t   cut1, cut2;

    // Stage 1: sort the vertices along the axis in removal order.
    vtx_t   va, vb, vc;
    coord_t pa, pb, pc;
    logic   bab, bbc, bac;

    always_comb
    begin
        va.x = tri_req.ax;
        va.y = tri_req.ay;
        vb.x = tri_req.bx;
        vb.y = tri_req.by_coord;
        vc.x = tri_req.cx;
        vc.y = tri_req.cy;
        pa   = pick_fn(tri_req.axis, va);
        pb   = pick_fn(tri_req.axis, vb);
        pc   = pick_fn(tri_req.axis, vc);
        bab  = before_c_fn(tri_req.remove_greater, pa, pb);
        bbc  = before_c_fn(tri_req.remove_greater, pb, pc);
        bac  = before_c_fn(tri_req.remove_greater, pa, pc);

        s1_next.gt   = tri_req.remove_greater;
        s1_next.axis = tri_req.axis;
        s1_next.clip = tri_req.clip_value;
        s1_next.va   = va;
        s1_next.vb   = vb;
        s1_next.vc   = vc;
        if (bab)
        begin
            if (bbc)
            begin
                s1_next.srt_a = va; s1_next.srt_b = vb; s1_next.srt_c = vc; s1_next.mir = 1'b0;
            end
            else if (bac)
            begin
                s1_next.srt_a = va; s1_next.srt_b = vc; s1_next.srt_c = vb; s1_next.mir = 1'b1;
            end
            else
            begin
                s1_next.srt_a = vc; s1_next.srt_b = va; s1_next.srt_c = vb; s1_next.mir = 1'b0;
            end
        end
        else
        begin
            if (bac)
            begin
                s1_next.srt_a = vb; s1_next.srt_b = va; s1_next.srt_c = vc; s1_next.mir = 1'b1;
            end
            else if (bbc)
            begin
                s1_next.srt_a = vb; s1_next.srt_b = vc; s1_next.srt_c = va; s1_next.mir = 1'b0;
            end
            else
            begin
                s1_next.srt_a = vc; s1_next.srt_b = vb; s1_next.srt_c = va; s1_next.mir = 1'b1;
            end
        end
    end

    // Stage 2: classify against the clip line and set up both divisions.
    coord_t ka, kb, kc;
    diff_t  ab, ac, bc, ca, cb;
    logic   split;

    always_comb
    begin
        ka    = pick_fn(s1_reg.axis, s1_reg.srt_a);
        kb    = pick_fn(s1_reg.axis, s1_reg.srt_b);
        kc    = pick_fn(s1_reg.axis, s1_reg.srt_c);
        ab    = DIFF_BITS'(kb) - DIFF_BITS'(ka);
        ac    = DIFF_BITS'(kc) - DIFF_BITS'(ka);
        bc    = DIFF_BITS'(kc) - DIFF_BITS'(kb);
        ca    = DIFF_BITS'(s1_reg.clip) - DIFF_BITS'(ka);
        cb    = DIFF_BITS'(s1_reg.clip) - DIFF_BITS'(kb);
        split = before_c_fn(s1_reg.gt, s1_reg.clip, kb);

        s2_next.gt    = s1_reg.gt;
        s2_next.mir   = s1_reg.mir;
        s2_next.va    = s1_reg.va;
        s2_next.vb    = s1_reg.vb;
        s2_next.vc    = s1_reg.vc;
        s2_next.srt_a = s1_reg.srt_a;
        s2_next.srt_b = s1_reg.srt_b;
        s2_next.srt_c = s1_reg.srt_c;
        if (!before_c_fn(s1_reg.gt, s1_reg.clip, kc))
            s2_next.kind = KIND_DROP;
        else if (!before_c_fn(s1_reg.gt, ka, s1_reg.clip))
            s2_next.kind = KIND_KEEP;
        else if (split)
            s2_next.kind = KIND_SPLIT;
        else
            s2_next.kind = KIND_CUT;
        s2_next.dpar = split ? ab : bc;
        s2_next.ac   = ac;
        s2_next.d1   = split ? dvec_fn(s1_reg.srt_b, s1_reg.srt_a)
                             : dvec_fn(s1_reg.srt_c, s1_reg.srt_a);
        s2_next.d2   = split ? dvec_fn(s1_reg.srt_c, s1_reg.srt_a)
                             : dvec_fn(s1_reg.srt_c, s1_reg.srt_b);
        s2_next.num1 = mag_fn(ca);
        s2_next.den1 = split ? mag_fn(ab) : mag_fn(ac);
        s2_next.num2 = split ? mag_fn(ca) : mag_fn(cb);
        s2_next.den2 = split ? mag_fn(ac) : mag_fn(bc);
    end

    // Stage 3: near-parallel test. A thin near edge keeps the triangle whole, a thin
    // far edge drops it.
    logic signed [WIDE_BITS-1:0] scaled;
    logic                        par;

    always_comb
    begin
        scaled = WIDE_BITS'(s2_reg.dpar) * WIDE_BITS'(TOL_SCALE);
        par    = before_fn(s2_reg.gt, scaled, WIDE_BITS'(s2_reg.ac));

        sb_next.mir   = s2_reg.mir;
        sb_next.va    = s2_reg.va;
        sb_next.vb    = s2_reg.vb;
        sb_next.vc    = s2_reg.vc;
        sb_next.srt_a = s2_reg.srt_a;
        sb_next.srt_b = s2_reg.srt_b;
        sb_next.srt_c = s2_reg.srt_c;
        sb_next.d1    = s2_reg.d1;
        sb_next.d2    = s2_reg.d2;
        sb_next.kind  = s2_reg.kind;
        if (par && s2_reg.kind == KIND_SPLIT)
            sb_next.kind = KIND_KEEP;
        else if (par && s2_reg.kind == KIND_CUT)
            sb_next.kind = KIND_DROP;
    end

    thpc_div u_div1 (
        .clk  (clk),
        .adv  (adv),
        .num  (s2_reg.num1),
        .den  (s2_reg.den1),
        .quot (t1)
    );

    thpc_div u_div2 (
        .clk  (clk),
        .adv  (adv),
        .num  (s2_reg.num2),
        .den  (s2_reg.den2),
        .quot (t2)
    );

    assign p2 = (sb_reg[QUOT_FRAC_BITS-1].kind == KIND_SPLIT) ? sb_reg[QUOT_FRAC_BITS-1].srt_a
                                                             : sb_reg[QUOT_FRAC_BITS-1].srt_b;

    thpc_lerp u_lerp1 (
        .clk (clk),
        .adv (adv),
        .t   (t1),
        .p   (sb_reg[QUOT_FRAC_BITS-1].srt_a),
        .d   (sb_reg[QUOT_FRAC_BITS-1].d1),
        .r   (cut1)
    );

    thpc_lerp u_lerp2 (
        .clk (clk),
        .adv (adv),
        .t   (t2),
        .p   (p2),
        .d   (sb_reg[QUOT_FRAC_BITS-1].d2),
        .r   (cut2)
    );

    // Output stage: a split request is shown twice, first and second triangle.
    assign last_now  = (oi_reg.sb.kind != KIND_SPLIT) || phase_reg;
    assign adv       = !ov_reg || (!clip_stall && last_now);
    assign tri_stall = !adv;

    assign ov_next    = sbv_reg[SB_LEN-1] && (sb_reg[SB_LEN-1].kind != KIND_DROP);
    assign oi_next.sb = sb_reg[SB_LEN-1];
    assign oi_next.c1 = cut1;
    assign oi_next.c2 = cut2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            phase_reg <= 1'b0;
            for (int k = 0; k < SB_LEN; k++)
                sbv_reg[k] <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg     <= tri_valid;
                v2_reg     <= v1_reg;
                sbv_reg[0] <= v2_reg;
                for (int k = 1; k < SB_LEN; k++)
                    sbv_reg[k] <= sbv_reg[k-1];
                ov_reg    <= ov_next;
                phase_reg <= 1'b0;
            end
            else if (ov_reg && !clip_stall)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            sb_reg[0] <= sb_next;
            for (int k = 1; k < SB_LEN; k++)
                sb_reg[k] <= sb_reg[k-1];
            oi_reg <= oi_next;
        end
    end

    always_comb
    begin
        unique case (oi_reg.sb.kind)
            KIND_KEEP:
                clip_req = tri_fn(oi_reg.sb.va, oi_reg.sb.vb, oi_reg.sb.vc, 1'b1);
            KIND_SPLIT:
            begin
                if (oi_reg.sb.mir)
                    clip_req = phase_reg
                        ? tri_fn(oi_reg.sb.srt_c, oi_reg.c1, oi_reg.c2, 1'b1)
                        : tri_fn(oi_reg.sb.srt_b, oi_reg.c1, oi_reg.sb.srt_c, 1'b0);
                else
                    clip_req = phase_reg
                        ? tri_fn(oi_reg.c1, oi_reg.sb.srt_c, oi_reg.c2, 1'b1)
                        : tri_fn(oi_reg.c1, oi_reg.sb.srt_b, oi_reg.sb.srt_c, 1'b0);
            end
            KIND_CUT:
                clip_req = oi_reg.sb.mir
                    ? tri_fn(oi_reg.c2, oi_reg.c1, oi_reg.sb.srt_c, 1'b1)
                    : tri_fn(oi_reg.c1, oi_reg.c2, oi_reg.sb.srt_c, 1'b1);
            default:
                clip_req = tri_fn(oi_reg.sb.va, oi_reg.sb.vb, oi_reg.sb.vc, 1'b1);
        endcase
    end

    assign clip_valid = ov_reg;

endmodule

FILE: rtl/thpc_checker.sv
// Port-level checks of the triangle half-plane clipper and their binding to the top level.
`include "triangle_half_plane_clipper_macros.svh"

module thpc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                tri_valid,
    input logic                tri_stall,
    input thpc_pkg::tri_req_t  tri_req,
    input logic                clip_valid,
    input logic                clip_stall,
    input thpc_pkg::clip_req_t clip_req
);
    import thpc_pkg::*;

    logic tri_take;

    assign tri_take = tri_valid && !tri_stall && (tri_req.axis || !tri_req.axis);

    // A held result must not change under a stall.
    `THPC_ASSERT_NEXT(a_out_hold, clk, rst_n, clip_valid && clip_stall, clip_valid && $stable(clip_req), "result changed while stalled")

    // The second triangle of a split follows right after the first is taken.
    `THPC_ASSERT_NEXT(a_split_pair, clk, rst_n, clip_valid && !clip_stall && !clip_req.last_of_run, clip_valid && clip_req.last_of_run, "second triangle of a split missing")

    // A stalled output freezes the pipeline, so no request may be taken.
    `THPC_ASSERT_NOW(a_stall_back, clk, rst_n, clip_valid && clip_stall, !tri_take, "request taken while output stalled")

    // While the first triangle of a split is shown, the input is held off.
    `THPC_ASSERT_NOW(a_split_hold, clk, rst_n, clip_valid && !clip_req.last_of_run, tri_stall, "request taken during a split")

endmodule

bind triangle_half_plane_clipper thpc_checker u_thpc_checker (.*);
